>>> rtl/mpet_pkg.sv
// Shared widths, constants and word types for the moving point / edge contact time block.
package mpet_pkg;

   localparam int IN_W   = 32;   // coordinate and time field width
   localparam int DIFF_W = 33;   // coordinate difference
   localparam int PROD_W = 66;   // product of two differences
   localparam int CROSS_W = 67;  // one cross product
   localparam int COEF_W = 68;   // quadratic coefficients a, b, c
   localparam int LIMB_W = 33;   // limb of a coefficient magnitude
   localparam int PP_W   = 2 * LIMB_W;
   localparam int SQ_W   = 4 * LIMB_W;
   localparam int RAD_W  = 136;  // discriminant
   localparam int ROOT_W = 67;   // integer square root of the discriminant
   localparam int NUM_W  = 70;   // root numerator and denominator
   localparam int TIME_W = 31;   // contact time word
   localparam int SPAN_W = 67;   // extent span and offset

   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int TIME_FRAC_BITS_DEF  = 30;

   typedef struct packed {
      logic signed [DIFF_W-1:0] spx;
      logic signed [DIFF_W-1:0] spy;
      logic signed [DIFF_W-1:0] dspx;
      logic signed [DIFF_W-1:0] dspy;
      logic signed [DIFF_W-1:0] ofx;
      logic signed [DIFF_W-1:0] ofy;
      logic signed [DIFF_W-1:0] dofx;
      logic signed [DIFF_W-1:0] dofy;
   } geom_type;

   typedef struct packed {
      geom_type                 geom;
      logic signed [IN_W-1:0]   lo;
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
      logic                     a_zero;
      logic                     b_zero;
      logic                     disc_neg;
   } root_side_type;

   typedef struct packed {
      geom_type               geom;
      logic signed [IN_W-1:0] lo;
   } div_side_type;

   typedef struct packed {
      logic                    en;
      logic signed [NUM_W-1:0] num;
      logic [NUM_W-1:0]        den;
   } lane_type;

endpackage

>>> rtl/moving_point_edge_time_of_impact_core.sv
// Top level: time of first contact between a moving point and a moving edge.
//
// Command channel: a word is taken at each rising edge with start high and
// busy low. busy is held low, so a new word can be issued every cycle.
// Each word yields exactly one result: rsp_strobe is high for one cycle with
// rsp_hit and rsp_contact_time (Q1.30 by default, zero when there is no hit).
// Throughput is one word per cycle. The pipeline depth is set by the 67-stage
// square root of the discriminant and the TIME_FRAC_BITS + 1 stage divider,
// one bit per stage, plus the coefficient and extent-test stages around them.
// The receiver cannot stall: results are issued in order, one per word.
// Reset clears every stage valid bit; words in flight are dropped and no
// strobe appears until a new word has passed through the pipeline.
module moving_point_edge_time_of_impact_core #(
   parameter int COORD_FRAC_BITS = mpet_pkg::COORD_FRAC_BITS_DEF,
   parameter int TIME_FRAC_BITS  = mpet_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [31:0]                  req_edge_start_x,
   input  logic signed [31:0]                  req_edge_start_y,
   input  logic signed [31:0]                  req_edge_end_x,
   input  logic signed [31:0]                  req_edge_end_y,
   input  logic signed [31:0]                  req_start_move_x,
   input  logic signed [31:0]                  req_start_move_y,
   input  logic signed [31:0]                  req_end_move_x,
   input  logic signed [31:0]                  req_end_move_y,
   input  logic signed [31:0]                  req_probe_x,
   input  logic signed [31:0]                  req_probe_y,
   input  logic signed [63:0]                  req_probe_move,
   input  logic signed [31:0]                  req_earliest_time,
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic [mpet_pkg::TIME_W-1:0]         rsp_contact_time
);
   localparam int IW  = mpet_pkg::IN_W;
   localparam int DW  = mpet_pkg::DIFF_W;
   localparam int PW  = mpet_pkg::PROD_W;
   localparam int XW  = mpet_pkg::CROSS_W;
   localparam int CW  = mpet_pkg::COEF_W;
   localparam int LW  = mpet_pkg::LIMB_W;
   localparam int PPW = mpet_pkg::PP_W;
   localparam int QSW = mpet_pkg::SQ_W;
   localparam int RW  = mpet_pkg::RAD_W;
   localparam int NW  = mpet_pkg::NUM_W;
   localparam int TW  = mpet_pkg::TIME_W;
   localparam int SW  = mpet_pkg::SPAN_W;
   localparam int EPS_RAW = ((1 << COORD_FRAC_BITS) + 5000) / 10000;
   localparam logic signed [SW-1:0] THR  = SW'(EPS_RAW) <<< TIME_FRAC_BITS;
   localparam logic signed [SW-1:0] NTHR = -THR;

   typedef struct packed {
      logic signed [IW-1:0] sx, sy, ex, ey, dsx, dsy, dex, dey, px, py, dpx, dpy, et;
   } raw_type;

   function automatic logic signed [PW-1:0] smul(logic signed [DW-1:0] x,
                                                 logic signed [DW-1:0] y);
      return PW'(x) * PW'(y);
   endfunction

   assign busy = 1'b0;

   // stage 0: capture the word
   logic    v0_ff;
   raw_type raw_ff, raw_in;
   always_comb begin
      raw_in.sx  = req_edge_start_x;
      raw_in.sy  = req_edge_start_y;
      raw_in.ex  = req_edge_end_x;
      raw_in.ey  = req_edge_end_y;
      raw_in.dsx = req_start_move_x;
      raw_in.dsy = req_start_move_y;
      raw_in.dex = req_end_move_x;
      raw_in.dey = req_end_move_y;
      raw_in.px  = req_probe_x;
      raw_in.py  = req_probe_y;
      raw_in.dpx = $signed(req_probe_move[63:32]);
      raw_in.dpy = $signed(req_probe_move[31:0]);
      raw_in.et  = req_earliest_time;
   end

   // stage 1: differences and clamped lower bound
   logic                 v1_ff;
   raw_type              raw1_ff;
   mpet_pkg::geom_type   geom1_ff, geom1_in;
   logic signed [IW-1:0] lo1_ff, lo1_in;
   always_comb begin
      geom1_in.spx  = DW'(raw_ff.sx)  - DW'(raw_ff.ex);
      geom1_in.spy  = DW'(raw_ff.sy)  - DW'(raw_ff.ey);
      geom1_in.dspx = DW'(raw_ff.dsx) - DW'(raw_ff.dex);
      geom1_in.dspy = DW'(raw_ff.dsy) - DW'(raw_ff.dey);
      geom1_in.ofx  = DW'(raw_ff.sx)  - DW'(raw_ff.px);
      geom1_in.ofy  = DW'(raw_ff.sy)  - DW'(raw_ff.py);
      geom1_in.dofx = DW'(raw_ff.dsx) - DW'(raw_ff.dpx);
      geom1_in.dofy = DW'(raw_ff.dsy) - DW'(raw_ff.dpy);
      lo1_in = raw_ff.et[IW-1] ? '0 : raw_ff.et;
   end

   // stage 2: sixteen products
   logic                 v2_ff;
   mpet_pkg::geom_type   geom2_ff;
   logic signed [IW-1:0] lo2_ff;
   logic signed [PW-1:0] pr_ff [16];
   logic signed [PW-1:0] pr_in [16];
   always_comb begin
      pr_in[0]  = smul(DW'(raw1_ff.dpx), geom1_ff.dspy);
      pr_in[1]  = smul(DW'(raw1_ff.dpy), geom1_ff.dspx);
      pr_in[2]  = smul(DW'(raw1_ff.dex), DW'(raw1_ff.dsy));
      pr_in[3]  = smul(DW'(raw1_ff.dey), DW'(raw1_ff.dsx));
      pr_in[4]  = smul(DW'(raw1_ff.px),  geom1_ff.dspy);
      pr_in[5]  = smul(DW'(raw1_ff.py),  geom1_ff.dspx);
      pr_in[6]  = smul(DW'(raw1_ff.dpx), geom1_ff.spy);
      pr_in[7]  = smul(DW'(raw1_ff.dpy), geom1_ff.spx);
      pr_in[8]  = smul(DW'(raw1_ff.ex),  DW'(raw1_ff.dsy));
      pr_in[9]  = smul(DW'(raw1_ff.ey),  DW'(raw1_ff.dsx));
      pr_in[10] = smul(DW'(raw1_ff.dex), DW'(raw1_ff.sy));
      pr_in[11] = smul(DW'(raw1_ff.dey), DW'(raw1_ff.sx));
      pr_in[12] = smul(DW'(raw1_ff.px),  geom1_ff.spy);
      pr_in[13] = smul(DW'(raw1_ff.py),  geom1_ff.spx);
      pr_in[14] = smul(DW'(raw1_ff.ex),  DW'(raw1_ff.sy));
      pr_in[15] = smul(DW'(raw1_ff.ey),  DW'(raw1_ff.sx));
   end

   // stage 3: cross products
   logic                 v3_ff;
   mpet_pkg::geom_type   geom3_ff;
   logic signed [IW-1:0] lo3_ff;
   logic signed [XW-1:0] cr_ff [8];
   logic signed [XW-1:0] cr_in [8];
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         cr_in[i] = XW'(pr_ff[2*i]) - XW'(pr_ff[2*i+1]);
      end
   end

   // stage 4: coefficients
   logic                    v4_ff;
   mpet_pkg::root_side_type sd4_ff, sd4_in;
   always_comb begin
      sd4_in          = '0;
      sd4_in.geom     = geom3_ff;
      sd4_in.lo       = lo3_ff;
      sd4_in.a        = CW'(cr_ff[0]) - CW'(cr_ff[1]);
      sd4_in.b        = CW'(cr_ff[2]) + CW'(cr_ff[3]) - CW'(cr_ff[4]) - CW'(cr_ff[5]);
      sd4_in.c        = CW'(cr_ff[6]) - CW'(cr_ff[7]);
   end

   // stage 5: zero flags and limb products of |b|^2 and |a||c|
   logic                    v5_ff;
   mpet_pkg::root_side_type sd5_ff, sd5_in;
   logic                    acneg5_ff;
   logic [PPW-1:0]          bll_ff, blh_ff, bhh_ff, all_ff, alh_ff, ahl_ff, ahh_ff;
   logic [CW-1:0]           bmag, amag, cmag;
   always_comb begin
      sd5_in        = sd4_ff;
      sd5_in.a_zero = (sd4_ff.a == '0);
      sd5_in.b_zero = (sd4_ff.b == '0);
      bmag = sd4_ff.b[CW-1] ? $unsigned(-sd4_ff.b) : $unsigned(sd4_ff.b);
      amag = sd4_ff.a[CW-1] ? $unsigned(-sd4_ff.a) : $unsigned(sd4_ff.a);
      cmag = sd4_ff.c[CW-1] ? $unsigned(-sd4_ff.c) : $unsigned(sd4_ff.c);
   end

   // stage 6: assemble b^2 and |a*c|
   logic                    v6_ff;
   mpet_pkg::root_side_type sd6_ff;
   logic                    acneg6_ff;
   logic [QSW-1:0]          bb_ff, bb_in, ac_ff, ac_in;
   always_comb begin
      bb_in = (QSW'(bhh_ff) << (2 * LW)) + (QSW'(blh_ff) << (LW + 1)) + QSW'(bll_ff);
      ac_in = (QSW'(ahh_ff) << (2 * LW)) + (QSW'(alh_ff) << LW) +
              (QSW'(ahl_ff) << LW) + QSW'(all_ff);
   end

   // stage 7: discriminant
   logic                    v7_ff;
   mpet_pkg::root_side_type sd7_ff, sq_side_in;
   logic signed [RW-1:0]    disc_ff, disc_in;
   logic [RW-1:0]           rad_in;
   always_comb begin
      if (acneg6_ff) begin
         disc_in = $signed(RW'(bb_ff)) + $signed(RW'(ac_ff) << 2);
      end else begin
         disc_in = $signed(RW'(bb_ff)) - $signed(RW'(ac_ff) << 2);
      end
      sq_side_in          = sd7_ff;
      sq_side_in.disc_neg = disc_ff[RW-1];
      rad_in              = disc_ff[RW-1] ? '0 : $unsigned(disc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
      raw_ff    <= raw_in;
      raw1_ff   <= raw_ff;
      geom1_ff  <= geom1_in;
      lo1_ff    <= lo1_in;
      geom2_ff  <= geom1_ff;
      lo2_ff    <= lo1_ff;
      pr_ff     <= pr_in;
      geom3_ff  <= geom2_ff;
      lo3_ff    <= lo2_ff;
      cr_ff     <= cr_in;
      sd4_ff    <= sd4_in;
      sd5_ff    <= sd5_in;
      acneg5_ff <= sd4_ff.a[CW-1] ^ sd4_ff.c[CW-1];
      bll_ff    <= PPW'(bmag[LW-1:0])    * PPW'(bmag[LW-1:0]);
      blh_ff    <= PPW'(bmag[LW-1:0])    * PPW'(bmag[2*LW-1:LW]);
      bhh_ff    <= PPW'(bmag[2*LW-1:LW]) * PPW'(bmag[2*LW-1:LW]);
      all_ff    <= PPW'(amag[LW-1:0])    * PPW'(cmag[LW-1:0]);
      alh_ff    <= PPW'(amag[LW-1:0])    * PPW'(cmag[2*LW-1:LW]);
      ahl_ff    <= PPW'(amag[2*LW-1:LW]) * PPW'(cmag[LW-1:0]);
      ahh_ff    <= PPW'(amag[2*LW-1:LW]) * PPW'(cmag[2*LW-1:LW]);
      sd6_ff    <= sd5_ff;
      acneg6_ff <= acneg5_ff;
      bb_ff     <= bb_in;
      ac_ff     <= ac_in;
      sd7_ff    <= sd6_ff;
      disc_ff   <= disc_in;
   end

   // square root of the discriminant
   logic                       sq_valid;
   logic [mpet_pkg::ROOT_W-1:0] sq_root;
   mpet_pkg::root_side_type    sq_side;

   mpet_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_value  (rad_in),
      .in_side   (sq_side_in),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // root setup: numerators over a positive denominator
   logic                          pv_ff;
   mpet_pkg::lane_type [1:0]      plane_ff, plane_in;
   mpet_pkg::div_side_type        pside_ff, pside_in;
   logic signed [NW-1:0]          s_e, b_e, c_e, twoa;
   always_comb begin
      s_e  = $signed(NW'(sq_root));
      b_e  = NW'(sq_side.b);
      c_e  = NW'(sq_side.c);
      twoa = NW'(sq_side.a) + NW'(sq_side.a);
      pside_in.geom = sq_side.geom;
      pside_in.lo   = sq_side.lo;
      if (sq_side.a_zero) begin
         plane_in[0].en  = !sq_side.b_zero;
         plane_in[0].num = sq_side.b[CW-1] ? c_e : -c_e;
         plane_in[0].den = sq_side.b[CW-1] ? $unsigned(-b_e) : $unsigned(b_e);
         plane_in[1]     = '0;
      end else begin
         plane_in[0].en  = !sq_side.disc_neg;
         plane_in[1].en  = !sq_side.disc_neg;
         plane_in[0].num = sq_side.a[CW-1] ? b_e - s_e : s_e - b_e;
         plane_in[1].num = sq_side.a[CW-1] ? s_e + b_e : -s_e - b_e;
         plane_in[0].den = sq_side.a[CW-1] ? $unsigned(-twoa) : $unsigned(twoa);
         plane_in[1].den = plane_in[0].den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= sq_valid;
      end
      plane_ff <= plane_in;
      pside_ff <= pside_in;
   end

   logic                   dv_valid;
   logic [1:0]             dv_ok;
   logic [1:0][TW-1:0]     dv_q;
   mpet_pkg::div_side_type dv_side;

   mpet_div #(
      .TIME_FRAC_BITS (TIME_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pv_ff),
      .in_lane   (plane_ff),
      .in_side   (pside_ff),
      .out_valid (dv_valid),
      .out_ok    (dv_ok),
      .out_q     (dv_q),
      .out_side  (dv_side)
   );

   // extent test, stage 1: lower bound and motion terms
   logic                   e1v_ff;
   mpet_pkg::geom_type     e1g_ff;
   logic [1:0]             e1ok_ff, e1ok_in;
   logic [1:0][TW-1:0]     e1q_ff;
   logic signed [SW-1:0]   mspx_ff [2], mofx_ff [2], mspy_ff [2], mofy_ff [2];
   logic signed [SW-1:0]   mspx_in [2], mofx_in [2], mspy_in [2], mofy_in [2];
   logic signed [SW-1:0]   qs [2];
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         qs[l]      = $signed(SW'(dv_q[l]));
         e1ok_in[l] = dv_ok[l] && ($signed({2'b00, dv_q[l]}) >= (TW + 2)'(dv_side.lo));
         mspx_in[l] = SW'(dv_side.geom.dspx) * qs[l];
         mofx_in[l] = SW'(dv_side.geom.dofx) * qs[l];
         mspy_in[l] = SW'(dv_side.geom.dspy) * qs[l];
         mofy_in[l] = SW'(dv_side.geom.dofy) * qs[l];
      end
   end

   // stage 2: spans and offsets at the root time
   logic                 e2v_ff;
   logic [1:0]           e2ok_ff;
   logic [1:0][TW-1:0]   e2q_ff;
   logic signed [SW-1:0] spx_ff [2], ofx_ff [2], spy_ff [2], ofy_ff [2];
   logic signed [SW-1:0] spx_in [2], ofx_in [2], spy_in [2], ofy_in [2];
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         spx_in[l] = (SW'(e1g_ff.spx) <<< TIME_FRAC_BITS) + mspx_ff[l];
         ofx_in[l] = (SW'(e1g_ff.ofx) <<< TIME_FRAC_BITS) + mofx_ff[l];
         spy_in[l] = (SW'(e1g_ff.spy) <<< TIME_FRAC_BITS) + mspy_ff[l];
         ofy_in[l] = (SW'(e1g_ff.ofy) <<< TIME_FRAC_BITS) + mofy_ff[l];
      end
   end

   // stage 3: pick the axis and fold the sign into the offset
   logic                 e3v_ff;
   logic [1:0]           e3ok_ff;
   logic [1:0][TW-1:0]   e3q_ff;
   logic signed [SW-1:0] span_ff [2], off_ff [2];
   logic signed [SW-1:0] span_in [2], off_in [2], span_s [2], off_s [2];
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (spx_ff[l] > THR || spx_ff[l] < NTHR) begin
            span_s[l] = spx_ff[l];
            off_s[l]  = ofx_ff[l];
         end else begin
            span_s[l] = spy_ff[l];
            off_s[l]  = ofy_ff[l];
         end
         span_in[l] = span_s[l][SW-1] ? -span_s[l] : span_s[l];
         off_in[l]  = span_s[l][SW-1] ? -off_s[l]  : off_s[l];
      end
   end

   // stage 4: offset within span
   logic               e4v_ff;
   logic [1:0]         pass_ff, pass_in;
   logic [1:0][TW-1:0] e4q_ff;
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         pass_in[l] = e3ok_ff[l] && !off_ff[l][SW-1] && (off_ff[l] <= span_ff[l]);
      end
   end

   // output: earliest passing root
   logic          strobe_ff, hit_ff, hit_in;
   logic [TW-1:0] time_ff, time_in;
   always_comb begin
      hit_in = pass_ff[0] || pass_ff[1];
      if (pass_ff[0] && pass_ff[1]) begin
         time_in = (e4q_ff[1] < e4q_ff[0]) ? e4q_ff[1] : e4q_ff[0];
      end else if (pass_ff[0]) begin
         time_in = e4q_ff[0];
      end else if (pass_ff[1]) begin
         time_in = e4q_ff[1];
      end else begin
         time_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1v_ff    <= 1'b0;
         e2v_ff    <= 1'b0;
         e3v_ff    <= 1'b0;
         e4v_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         e1v_ff    <= dv_valid;
         e2v_ff    <= e1v_ff;
         e3v_ff    <= e2v_ff;
         e4v_ff    <= e3v_ff;
         strobe_ff <= e4v_ff;
      end
      e1g_ff  <= dv_side.geom;
      e1ok_ff <= e1ok_in;
      e1q_ff  <= dv_q;
      mspx_ff <= mspx_in;
      mofx_ff <= mofx_in;
      mspy_ff <= mspy_in;
      mofy_ff <= mofy_in;
      e2ok_ff <= e1ok_ff;
      e2q_ff  <= e1q_ff;
      spx_ff  <= spx_in;
      ofx_ff  <= ofx_in;
      spy_ff  <= spy_in;
      ofy_ff  <= ofy_in;
      e3ok_ff <= e2ok_ff;
      e3q_ff  <= e2q_ff;
      span_ff <= span_in;
      off_ff  <= off_in;
      pass_ff <= pass_in;
      e4q_ff  <= e3q_ff;
      hit_ff  <= hit_in;
      time_ff <= time_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_contact_time = time_ff;
endmodule

>>> rtl/mpet_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband word.
module mpet_isqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [mpet_pkg::RAD_W-1:0]         in_value,
   input  mpet_pkg::root_side_type            in_side,
   output logic                               out_valid,
   output logic [mpet_pkg::ROOT_W-1:0]        out_root,
   output mpet_pkg::root_side_type            out_side
);
   localparam int N  = mpet_pkg::ROOT_W;
   localparam int RW = mpet_pkg::RAD_W;

   logic                    valid_ff [N];
   logic [RW-1:0]           rem_ff   [N];
   logic [N-1:0]            root_ff  [N];
   mpet_pkg::root_side_type side_ff  [N];

   genvar g;
   for (g = 0; g < N; g++) begin : gen_stage
      localparam int K = N - 1 - g;
      logic                    v_prev;
      logic [RW-1:0]           rem_prev;
      logic [N-1:0]            root_prev;
      mpet_pkg::root_side_type side_prev;
      logic [RW-1:0]           trial;
      logic [RW-1:0]           rem_in;
      logic [N-1:0]            root_in;

      if (g == 0) begin : gen_first
         assign v_prev    = in_valid;
         assign rem_prev  = in_value;
         assign root_prev = '0;
         assign side_prev = in_side;
      end else begin : gen_next
         assign v_prev    = valid_ff[g-1];
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign side_prev = side_ff[g-1];
      end

      // remainder holds value - root^2; try setting bit K
      always_comb begin
         trial = (RW'(root_prev) << (K + 1)) | (RW'(1) << (2 * K));
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (N'(1) << K);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= v_prev;
         end
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
         side_ff[g] <= side_prev;
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];
endmodule

>>> rtl/mpet_div.sv
// Two-lane pipelined restoring divider giving floor(num * 2^T / den) for 0 <= num <= den.
module mpet_div #(
   parameter int TIME_FRAC_BITS = mpet_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  mpet_pkg::lane_type [1:0]                 in_lane,
   input  mpet_pkg::div_side_type                   in_side,
   output logic                                     out_valid,
   output logic [1:0]                               out_ok,
   output logic [1:0][mpet_pkg::TIME_W-1:0]         out_q,
   output mpet_pkg::div_side_type                   out_side
);
   localparam int S  = TIME_FRAC_BITS + 1;
   localparam int NW = mpet_pkg::NUM_W;
   localparam int QW = mpet_pkg::TIME_W;

   typedef struct packed {
      logic          ok;
      logic [NW-1:0] rem;
      logic [NW-1:0] den;
      logic [QW-1:0] q;
   } lane_state_type;

   logic                        valid_ff [S];
   lane_state_type [1:0]        lane_ff  [S];
   mpet_pkg::div_side_type      side_ff  [S];

   genvar g;
   for (g = 0; g < S; g++) begin : gen_stage
      localparam int K = TIME_FRAC_BITS - g;
      logic                   v_prev;
      mpet_pkg::div_side_type side_prev;
      lane_state_type [1:0]   lane_in;

      if (g == 0) begin : gen_first
         assign v_prev    = in_valid;
         assign side_prev = in_side;
         // top quotient bit is set only when num equals den
         always_comb begin
            for (int l = 0; l < 2; l++) begin
               lane_in[l].den = in_lane[l].den;
               lane_in[l].ok  = in_lane[l].en && !in_lane[l].num[NW-1] &&
                                ($unsigned(in_lane[l].num) <= in_lane[l].den);
               if ($unsigned(in_lane[l].num) == in_lane[l].den) begin
                  lane_in[l].rem = '0;
                  lane_in[l].q   = QW'(1) << K;
               end else begin
                  lane_in[l].rem = $unsigned(in_lane[l].num);
                  lane_in[l].q   = '0;
               end
            end
         end
      end else begin : gen_next
         logic [1:0][NW-1:0] shifted;
         assign v_prev    = valid_ff[g-1];
         assign side_prev = side_ff[g-1];
         always_comb begin
            for (int l = 0; l < 2; l++) begin
               shifted[l]     = lane_ff[g-1][l].rem << 1;
               lane_in[l]     = lane_ff[g-1][l];
               if (shifted[l] >= lane_ff[g-1][l].den) begin
                  lane_in[l].rem = shifted[l] - lane_ff[g-1][l].den;
                  lane_in[l].q   = lane_ff[g-1][l].q | (QW'(1) << K);
               end else begin
                  lane_in[l].rem = shifted[l];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= v_prev;
         end
         lane_ff[g] <= lane_in;
         side_ff[g] <= side_prev;
      end
   end

   assign out_valid = valid_ff[S-1];
   assign out_side  = side_ff[S-1];
   assign out_ok    = {lane_ff[S-1][1].ok, lane_ff[S-1][0].ok};
   assign out_q     = {lane_ff[S-1][1].q, lane_ff[S-1][0].q};
endmodule
